// ----- rtl/function_start_extent_finder_top_assert.svh -----
// Assertion macros shared by the checker of the top level.
`ifndef FUNCTION_START_EXTENT_FINDER_TOP_ASSERT_SVH
`define FUNCTION_START_EXTENT_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FSEF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FSEF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/fsef_pkg.sv -----
package fsef_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] extent;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] target_offset;
      logic [63:0] text_size;
   } cfg_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_result_type;

   // Result status codes
   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_MALFORMED = 3'd1;
   localparam logic [2:0] ST_SKIPPED   = 3'd2;
   localparam logic [2:0] ST_NO_NEXT   = 3'd3;
   localparam logic [2:0] ST_OUTSIDE   = 3'd4;

   // Register indexes
   localparam logic CSR_TARGET_OFFSET = 1'b0;
   localparam logic CSR_TEXT_SIZE     = 1'b1;

   // Varint decoding
   localparam int unsigned CONT_BIT      = 7;
   localparam logic [6:0]  OVERLONG_MASK = 7'h7e;
   // Group g of seven bits sits at shift 7*g; group 9 is shift 63, group 10 is past 64.
   localparam logic [3:0]  GROUP_LAST    = 4'd9;
   localparam logic [3:0]  GROUP_OVER    = 4'd10;

endpackage

// ----- rtl/fsef_input_stage.sv -----
module fsef_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  fsef_pkg::req_word_type req_word,
   output logic                  req_stall,
   input  logic                  advance,
   output logic                  in_valid,
   output fsef_pkg::req_word_type in_word
);
   import fsef_pkg::*;

   logic         in_valid_ff;
   logic         in_valid_in;
   req_word_type in_word_ff;

   // Hold the word only while the decode stage cannot move.
   assign req_stall   = in_valid_ff & ~advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   assign in_valid = in_valid_ff;
   assign in_word  = in_word_ff;

endmodule

// ----- rtl/fsef_decode.sv -----
module fsef_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  fsef_pkg::req_word_type   in_word,
   input  fsef_pkg::cfg_type        cfg,
   output fsef_pkg::step_result_type result
);
   import fsef_pkg::*;

   logic [63:0] running_address_ff, running_address_in;
   logic [63:0] partial_delta_ff, partial_delta_in;
   logic [3:0]  group_ff, group_in;
   logic        target_matched_ff, target_matched_in;
   logic        answer_given_ff, answer_given_in;

   logic [6:0]  shift_amt;
   logic [63:0] chunk;
   logic [63:0] delta;
   logic [63:0] target_gap;
   logic [63:0] size_gap;
   logic [63:0] run_sum;
   logic        last;

   assign last       = in_word.stream_end;
   assign shift_amt  = {group_ff, 3'b000} - {3'b000, group_ff};
   assign chunk      = {57'd0, in_word.data_byte[6:0]} << shift_amt;
   assign delta      = partial_delta_ff | chunk;
   assign target_gap = cfg.target_offset - running_address_ff;
   assign size_gap   = cfg.text_size - running_address_ff;
   assign run_sum    = running_address_ff + delta;

   always_comb begin
      running_address_in = running_address_ff;
      partial_delta_in   = partial_delta_ff;
      group_in           = group_ff;
      target_matched_in  = target_matched_ff;
      answer_given_in    = answer_given_ff;
      result.emit        = 1'b0;
      result.word.status = ST_FOUND;
      result.word.extent = 64'd0;

      if (fire) begin
         if (answer_given_ff) begin
            // drop bytes until the stream ends
         end else if (cfg.target_offset >= cfg.text_size) begin
            result.emit        = 1'b1;
            result.word.status = ST_OUTSIDE;
         end else if (group_ff == GROUP_OVER) begin
            result.emit        = 1'b1;
            result.word.status = ST_MALFORMED;
         end else if (group_ff == GROUP_LAST &&
                      (in_word.data_byte[6:0] & OVERLONG_MASK) != 7'd0) begin
            result.emit        = 1'b1;
            result.word.status = ST_MALFORMED;
         end else if (in_word.data_byte[CONT_BIT]) begin
            partial_delta_in = delta;
            group_in         = group_ff + 4'd1;
            if (last) begin
               result.emit        = 1'b1;
               result.word.status = ST_MALFORMED;
            end
         end else begin
            partial_delta_in = 64'd0;
            group_in         = 4'd0;
            if (delta == 64'd0 || running_address_ff > cfg.text_size ||
                delta > size_gap) begin
               result.emit        = 1'b1;
               result.word.status = ST_MALFORMED;
            end else begin
               running_address_in = run_sum;
               if (target_matched_ff) begin
                  result.emit        = 1'b1;
                  result.word.status = ST_FOUND;
                  result.word.extent = delta - target_gap;
               end else if (running_address_ff > cfg.target_offset ||
                            delta > target_gap) begin
                  result.emit        = 1'b1;
                  result.word.status = ST_SKIPPED;
               end else begin
                  target_matched_in = (delta == target_gap);
                  if (last) begin
                     result.emit        = 1'b1;
                     result.word.status = ST_NO_NEXT;
                  end
               end
            end
         end

         if (result.emit) begin
            answer_given_in = 1'b1;
         end

         // The final byte clears the whole stream state.
         if (last) begin
            running_address_in = 64'd0;
            partial_delta_in   = 64'd0;
            group_in           = 4'd0;
            target_matched_in  = 1'b0;
            answer_given_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_address_ff <= 64'd0;
         partial_delta_ff   <= 64'd0;
         group_ff           <= 4'd0;
         target_matched_ff  <= 1'b0;
         answer_given_ff    <= 1'b0;
      end else begin
         running_address_ff <= running_address_in;
         partial_delta_ff   <= partial_delta_in;
         group_ff           <= group_in;
         target_matched_ff  <= target_matched_in;
         answer_given_ff    <= answer_given_in;
      end
   end

endmodule

// ----- rtl/fsef_output_stage.sv -----
module fsef_output_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  fsef_pkg::step_result_type result,
   output logic                      advance,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fsef_pkg::rsp_word_type    rsp_word
);
   import fsef_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;

   // Advance whenever the result register is empty or being drained.
   assign advance      = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = advance ? result.emit : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         rsp_word_ff <= result.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- rtl/function_start_extent_finder_top.sv -----
// Channel   Direction  Ports                                   Word
// request   in         req_valid, req_stall, req_word          data_byte, stream_end
// response  out        rsp_valid, rsp_stall, rsp_word          status, extent
// csr       in         csr_write_enable, csr_index, csr_write_data  target_offset, text_size
//
// One byte per cycle unless stalled; a response is registered behind the input register.
// The decode stage (varint assembly, running sum and 64-bit compares) sets the byte rate.
// Synchronous active-high reset clears both registers, the stream state and both valid bits.
// A stalled response holds the decode stage; the request side stalls only once its input
// register is full as well.
module function_start_extent_finder_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsef_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fsef_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [63:0]           csr_write_data
);
   import fsef_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic            advance;
   logic            in_valid;
   req_word_type    in_word;
   step_result_type result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_OFFSET: cfg_in.target_offset = csr_write_data;
            CSR_TEXT_SIZE:     cfg_in.text_size     = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsef_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   fsef_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .fire    (in_valid & advance),
      .in_word (in_word),
      .cfg     (cfg_ff),
      .result  (result)
   );

   fsef_output_stage u_output_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- rtl/fsef_checker.sv -----
`include "function_start_extent_finder_top_assert.svh"

module fsef_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input fsef_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input fsef_pkg::rsp_word_type rsp_word
);
   import fsef_pkg::*;

   logic rsp_wait;
   logic req_wait;
   logic req_take;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign req_wait = req_valid && req_stall;
   assign req_take = req_valid && !req_stall;

   // A stalled response word holds.
   `FSEF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_word), "rsp word moved")

   // A stalled request word holds.
   `FSEF_ASSERT_NEXT(a_req_hold, clock, reset, req_wait, req_valid && $stable(req_word), "req word moved")

   // Requests stall only behind a stalled response.
   `FSEF_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_wait, "req stall, no rsp stall")

   // A fresh response follows an accepted request byte.
   `FSEF_ASSERT_NOW(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_take, 2), "rsp, no byte")

endmodule

bind function_start_extent_finder_top fsef_checker u_checker (.*);
